// ===== rtl/wso_pkg.sv =====
// wso_pkg: shared constants and the sine table generator for the
// wavetable sine oscillator. Depends on nothing; used by the top level and the testbench.

package wso_pkg;

  // Command codes carried in the cmd field of an input word
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_RETUNE = 1'b1;

  // Fade weight is Q16; one equals 2^16 and needs 17 bits
  localparam int unsigned WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd10000;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Table entry i of a 2^addr_w entry full-cycle sine, Q1.15.
  // Quarter wave is a Q30 Taylor series to x^13, then rounded.
  function automatic logic signed [15:0] wso_rom_value(input longint unsigned idx,
                                                       input int unsigned addr_w);
    longint unsigned n;
    longint unsigned m;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned q;
    n    = 64'd1 << addr_w;
    m    = idx << 2;
    quad = m >> addr_w;
    r    = m & (n - 64'd1);
    if (quad[0]) begin
      r = n - r;
    end
    x    = (r * HALF_PI_Q30) >> addr_w;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    q    = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return (quad >= 64'd2) ? -$signed(16'(q)) : $signed(16'(q));
  endfunction

endpackage

// ===== rtl/wavetable_sine_oscillator_crossfade.sv =====
// Wavetable sine oscillator with linear interpolation and retune crossfade.
// Depends on wso_pkg (constants, sine table generator).
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------
//  input    | in_valid / in_stall         | cmd, tuning_word
//  output   | out_valid / out_stall       | sample, fading
//  config   | cfg_write_en                | cfg_write_data (amplitude)
//
// A retune word is handled in S_IDLE. A tick runs one voice, or two with a
// fade, each through phase multiply, ROM read, interpolate and scale; then a
// divide, or with a fade the weight multiply, mix add and divide. rst is
// synchronous and sets amplitude to 10000. A finished word waits in S_OUT
// while the output register is stalled; in_stall stays high until the
// sequencer is back in S_IDLE.

module wavetable_sine_oscillator_crossfade
  import wso_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 2048,
  parameter int unsigned FADE_STEP  = 52
) (
  input  logic                       clk,
  input  logic                       rst,
  // input words
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [31:0]                tuning_word,
  // result words
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       fading,
  // amplitude register
  input  logic                       cfg_write_en,
  input  logic [AMP_W-1:0]           cfg_write_data
);

  localparam int unsigned ADDR_W = $clog2(TABLE_SIZE);

  // Sine ROM, generated at elaboration
  typedef logic signed [15:0] rom_t [TABLE_SIZE];

  function automatic rom_t rom_build();
    rom_t t;
    for (int i = 0; i < int'(TABLE_SIZE); i++) begin
      t[i] = wso_rom_value(64'(i), ADDR_W);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = rom_build();

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_READ, S_INTERP, S_SCALE, S_MIX, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t               state;
  logic                 pass;          // 0: previous tuning voice, 1: current
  logic [AMP_W-1:0]     amplitude;
  logic [31:0]          sample_count;
  logic [31:0]          current_tuning;
  logic [31:0]          previous_tuning;
  logic [WEIGHT_W-1:0]  fade_weight;
  logic                 fade_active;
  logic [31:0]          phase;
  logic signed [15:0]   rom_k;
  logic signed [15:0]   rom_k1;
  logic signed [33:0]   interp;
  logic signed [47:0]   old_voice;
  logic signed [47:0]   new_voice;
  logic signed [42:0]   prod_hi;
  logic signed [42:0]   prod_lo;
  logic signed [63:0]   mix;
  logic signed [16:0]   quot;

  // Table index and Q16 fraction of the phase
  logic [ADDR_W-1:0] idx_k;
  logic [ADDR_W-1:0] idx_k1;
  logic [15:0]       frac;
  assign idx_k  = phase[31 -: ADDR_W];
  assign idx_k1 = idx_k + 1'b1;
  assign frac   = phase[31-ADDR_W -: 16];

  // Sine ROM, two synchronous read ports
  always_ff @(posedge clk) begin
    rom_k  <= SINE_ROM[idx_k];
    rom_k1 <= SINE_ROM[idx_k1];
  end

  // Phase of the selected voice (low 32 bits of count times tuning)
  logic [31:0] phase_next;
  assign phase_next = sample_count * (pass ? current_tuning : previous_tuning);

  // Linear interpolation between adjacent entries
  logic [16:0]        frac_c;
  logic signed [33:0] interp_a;
  logic signed [33:0] interp_b;
  assign frac_c   = 17'd65536 - {1'b0, frac};
  assign interp_a = rom_k * $signed({1'b0, frac_c});
  assign interp_b = rom_k1 * $signed({2'b00, frac});

  // Amplitude scaling
  logic signed [49:0] voice_prod;
  assign voice_prod = interp * $signed({1'b0, amplitude});

  // Crossfade: old * 2^16 + (new - old) * w, with the product in two halves
  logic signed [48:0] voice_diff;
  logic signed [42:0] prod_hi_next;
  logic signed [42:0] prod_lo_next;
  assign voice_diff   = 49'(new_voice) - 49'(old_voice);
  assign prod_hi_next = $signed(voice_diff[48:24]) * $signed({1'b0, fade_weight});
  assign prod_lo_next = $signed({1'b0, voice_diff[23:0]}) * $signed({1'b0, fade_weight});

  logic signed [63:0] mix_next;
  assign mix_next = (64'(old_voice) <<< 16) + (64'(prod_hi) <<< 24) + 64'(prod_lo);

  // Truncating divides toward zero: bias negatives before the shift
  logic signed [47:0] voice_bias;
  logic signed [63:0] mix_bias;
  assign voice_bias = new_voice + (new_voice[47] ? 48'sh0000_7FFF_FFFF : 48'sh0);
  assign mix_bias   = mix + (mix[63] ? 64'sh0000_7FFF_FFFF_FFFF : 64'sh0);

  // Fade weight step, saturating at one
  logic [WEIGHT_W:0] weight_sum;
  assign weight_sum = {1'b0, fade_weight} + (WEIGHT_W + 1)'(FADE_STEP);

  // Output saturation
  logic signed [SAMPLE_W-1:0] sample_sat;
  always_comb begin
    if (quot > 17'sd32767) begin
      sample_sat = 16'sh7FFF;
    end else if (quot < -17'sd32768) begin
      sample_sat = 16'sh8000;
    end else begin
      sample_sat = quot[SAMPLE_W-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);

  // Output register loads when it is empty or being drained
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pass            <= 1'b1;
      amplitude       <= AMP_RESET;
      sample_count    <= '0;
      current_tuning  <= '0;
      previous_tuning <= '0;
      fade_weight     <= WEIGHT_ONE;
      fade_active     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        amplitude <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_RETUNE) begin
              if (tuning_word != current_tuning) begin
                previous_tuning <= current_tuning;
                current_tuning  <= tuning_word;
                fade_weight     <= '0;
                fade_active     <= 1'b1;
              end
            end else begin
              // no fade: only the current voice is needed
              pass  <= !fade_active;
              state <= S_PHASE;
            end
          end
        end
        S_PHASE: begin
          phase <= phase_next;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_INTERP;
        end
        S_INTERP: begin
          interp <= interp_a + interp_b;
          state  <= S_SCALE;
        end
        S_SCALE: begin
          if (!pass) begin
            old_voice <= voice_prod[47:0];
            pass      <= 1'b1;
            state     <= S_PHASE;
          end else begin
            new_voice <= voice_prod[47:0];
            state     <= S_MIX;
          end
        end
        S_MIX: begin
          if (fade_active) begin
            prod_hi <= prod_hi_next;
            prod_lo <= prod_lo_next;
            state   <= S_SUM;
          end else begin
            quot  <= 17'(voice_bias >>> 31);
            state <= S_OUT;
          end
        end
        S_SUM: begin
          mix   <= mix_next;
          state <= S_DIV;
        end
        S_DIV: begin
          quot  <= 17'(mix_bias >>> 47);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            sample       <= sample_sat;
            fading       <= fade_active;
            sample_count <= sample_count + 32'd1;
            if (fade_active) begin
              if (fade_weight >= WEIGHT_ONE) begin
                fade_active <= 1'b0;
              end
              if (weight_sum > {1'b0, WEIGHT_ONE}) begin
                fade_weight <= WEIGHT_ONE;
              end else begin
                fade_weight <= weight_sum[WEIGHT_W-1:0];
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_wavetable_sine_oscillator_crossfade.sv =====
`timescale 1ns / 100ps
// Testbench for the wavetable sine oscillator with retune crossfade.
// Depends on wso_pkg and the wavetable_sine_oscillator_crossfade top level.

module tb_wavetable_sine_oscillator_crossfade
  import wso_pkg::*;
();

  localparam int unsigned TAB_LEN   = 2048;
  localparam int unsigned FADE_INC  = 52;
  localparam int unsigned W_ONE     = 65536;
  localparam longint      VOICE_DIV = longint'(1) << 31;
  localparam longint      MIX_DIV   = longint'(1) << 47;
  localparam int          SETTLE    = 40;   // > worst tick latency plus margin

  typedef struct {
    logic        cmd;
    logic [31:0] tune;
  } osc_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fading;
  } osc_sample_t;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_BUSY} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = CMD_TICK;
  logic [31:0]                tuning_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       fading;
  logic                       cfg_write_en = 1'b0;
  logic [AMP_W-1:0]           cfg_write_data = '0;

  wavetable_sine_oscillator_crossfade i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .tuning_word    (tuning_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sample         (sample),
    .fading         (fading),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Oscillator state as seen by the predictor
  logic signed [15:0] sine_tab [0:TAB_LEN-1];
  logic [AMP_W-1:0]   amp = AMP_RESET;
  logic [31:0]        smp_count = '0;
  logic [31:0]        cur_tune = '0;
  logic [31:0]        prev_tune = '0;
  int unsigned        weight = W_ONE;
  logic               fade_on = 1'b0;

  osc_word_t   words_to_send [$];
  osc_sample_t samples_due [$];
  int          err_count = 0;
  logic [31:0] last_tune = '0;   // last retune word queued, tracks cur_tune

  // Full-cycle Q1.15 sine entry; quarter wave from a Q30 Taylor series
  function automatic logic signed [15:0] sine_point(input int unsigned i);
    longint unsigned m, quad, r, x, x2, term, sum, q;
    logic signed [15:0] v;
    m    = 4 * i;
    quad = m / TAB_LEN;
    r    = m - quad * TAB_LEN;
    if (quad[0]) begin
      r = TAB_LEN - r;
    end
    x    = (r * HALF_PI_Q30) / TAB_LEN;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum * 32767 + (64'd1 << 29)) >> 30;
    if (q > 32767) begin
      q = 32767;
    end
    v = 16'(q);
    return (quad >= 2) ? -v : v;
  endfunction

  // Interpolated table value times amplitude, scaled by 2^31
  function automatic longint voice_at(input logic [31:0] tune);
    logic [31:0] phase;
    logic [10:0] k, k1;
    longint      frac, interp;
    phase  = smp_count * tune;
    k      = phase[31:21];
    k1     = k + 11'd1;
    frac   = longint'(phase[20:5]);
    interp = longint'(sine_tab[k]) * (65536 - frac) + longint'(sine_tab[k1]) * frac;
    return interp * longint'(amp);
  endfunction

  // Advance the predicted oscillator by one accepted word
  task automatic osc_step(input logic c, input logic [31:0] tw);
    longint      mix, s, w;
    osc_sample_t res;
    if (c == CMD_RETUNE) begin
      if (tw != cur_tune) begin
        prev_tune = cur_tune;
        cur_tune  = tw;
        weight    = 0;
        fade_on   = 1'b1;
      end
    end else begin
      res.fading = fade_on;
      if (fade_on) begin
        w   = longint'(weight);
        mix = voice_at(prev_tune) * (65536 - w) + voice_at(cur_tune) * w;
        s   = mix / MIX_DIV;
        if (weight >= W_ONE) begin
          fade_on = 1'b0;
        end
        weight = weight + FADE_INC;
        if (weight > W_ONE) begin
          weight = W_ONE;
        end
      end else begin
        s = voice_at(cur_tune) / VOICE_DIV;
      end
      if (s > 32767) begin
        s = 32767;
      end
      if (s < -32768) begin
        s = -32768;
      end
      res.sample = 16'(s);
      samples_due.push_back(res);
      smp_count = smp_count + 32'd1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    err_count++;
  endtask

  // Input side: acceptance feeds the predictor
  logic in_taken = 1'b0;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      osc_step(cmd, tuning_word);
      in_taken = 1'b1;
    end
  end

  // Sender: bursts of random length separated by random gaps
  int        burst_left = 0;
  int        gap_left = 0;
  osc_word_t nxt;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_taken = 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        nxt = words_to_send.pop_front();
        cmd         <= nxt.cmd;
        tuning_word <= nxt.tune;
        in_valid    <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between open, choppy and busy stretches
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_stall <= 1'b0;
      RX_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
      default:   out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Output check against the oldest predicted sample
  osc_sample_t got_ref;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (samples_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word sample=%0d fading=%0b", sample, fading));
      end else begin
        got_ref = samples_due.pop_front();
        if (sample !== got_ref.sample) begin
          report_mismatch($sformatf("sample %0d, predicted %0d", sample, got_ref.sample));
        end
        if (fading !== got_ref.fading) begin
          report_mismatch($sformatf("fading %0b, predicted %0b", fading, got_ref.fading));
        end
      end
    end
  end

  // Stimulus helpers
  task automatic queue_word(input logic c, input logic [31:0] tw);
    osc_word_t wd;
    wd.cmd  = c;
    wd.tune = tw;
    words_to_send.push_back(wd);
    if (c == CMD_RETUNE) begin
      last_tune = tw;
    end
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(CMD_TICK, $urandom);
  endtask

  // Wait until every word is taken and every sample is back, then settle
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || samples_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_amp(input logic [AMP_W-1:0] v);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
    cfg_write_data <= AMP_W'($urandom);
    amp = v;
  endtask

  // Ticks mixed with retunes; retune words lean toward edge cases
  task automatic queue_mix(input int n, input int retune_pct);
    int unsigned pick;
    logic [31:0] tw;
    repeat (n) begin
      if ($urandom_range(0, 99) < retune_pct) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          tw = last_tune;                          // same word, ignored
        end else if (pick < 50) begin
          tw = $urandom;
        end else if (pick < 75) begin
          tw = $urandom_range(1, 32'h0010_0000);   // slow sweep, fraction heavy
        end else if (pick < 90) begin
          tw = 32'hFFFF_FFFF - $urandom_range(0, 32'h0010_0000);
        end else begin
          tw = '0;
        end
        queue_word(CMD_RETUNE, tw);
      end else begin
        queue_word(CMD_TICK, $urandom);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < TAB_LEN; i++) begin
      sine_tab[i] = sine_point(i);
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset state, same-word retunes, retune during a fade, edge words
    queue_word(CMD_TICK, 32'hFFFF_FFFF);
    queue_word(CMD_TICK, '0);
    queue_word(CMD_RETUNE, '0);
    queue_word(CMD_TICK, '0);
    queue_word(CMD_RETUNE, 32'h8000_0000);
    queue_ticks(3);
    queue_word(CMD_RETUNE, 32'h8000_0000);
    queue_word(CMD_RETUNE, 32'hFFFF_FFFF);
    queue_ticks(2);
    queue_word(CMD_RETUNE, 32'h0000_0001);
    queue_ticks(2);
    queue_word(CMD_RETUNE, 32'h0000_0020);
    queue_ticks(1);
    queue_word(CMD_RETUNE, 32'h7FFF_FFFF);
    queue_ticks(1);
    queue_word(CMD_RETUNE, 32'h001F_FFE0);
    queue_ticks(2);
    drain();

    // Full amplitude; one fade runs to completion and saturates
    write_amp(15'd32767);
    queue_word(CMD_RETUNE, 32'h0123_4567);
    queue_ticks(1300);
    queue_mix(60, 20);
    drain();

    write_amp(15'd0);
    queue_mix(80, 20);
    drain();

    write_amp(15'd1);
    queue_mix(80, 25);
    drain();

    write_amp(AMP_W'($urandom));
    queue_mix(100, 10);
    drain();

    write_amp(15'd32767);
    queue_mix(100, 40);
    drain();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wso_pkg.sv
rtl/wavetable_sine_oscillator_crossfade.sv
sim/tb_wavetable_sine_oscillator_crossfade.sv
